>>> rtl/core/cfps_pkg.sv
// Package for the cube face project/sort block: types, constants, face tables.
// No dependencies.
`default_nettype none
package cfps_pkg;
    localparam int QW = 26;   // transformed value width (Q.14)
    localparam int KW = 28;   // depth key width (sum of four)
    localparam logic [1:0] RegRowX = 2'd0;
    localparam logic [1:0] RegRowY = 2'd1;
    localparam logic [1:0] RegRowZ = 2'd2;
    localparam logic signed [17:0] ScrMax = 18'sd131071;
    localparam logic signed [17:0] ScrMin = -18'sd131072;

    typedef logic [2:0] face_t;

    // box corner of face f, slot j; corner bit0=x, bit1=y, bit2=z
    function automatic logic [2:0] face_corner(input face_t f, input logic [1:0] j);
        logic [11:0] row;
        begin
            case (f)
                3'd0: row = {3'd1, 3'd0, 3'd4, 3'd5};
                3'd1: row = {3'd7, 3'd6, 3'd2, 3'd3};
                3'd2: row = {3'd2, 3'd6, 3'd4, 3'd0};
                3'd3: row = {3'd3, 3'd2, 3'd0, 3'd1};
                3'd4: row = {3'd7, 3'd3, 3'd1, 3'd5};
                3'd5: row = {3'd6, 3'd7, 3'd5, 3'd4};
                default: row = '0;
            endcase
            face_corner = row[j*3 +: 3];
        end
    endfunction

    // request handed from front to back: one box, classified and sorted
    typedef struct packed {
        logic signed [6:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
        logic [8:0] u0, u1, u2, u22, u3, u4;
        logic [7:0] v0, v1, v2;
        logic [11:0] cen_x, cen_y;
        logic [17:0] order;   // six face indices, slot 0 in low bits
    } box_req_t;
endpackage
`default_nettype wire

>>> rtl/core/cfps_front.sv
// Front part: accepts a box, computes corner depths one corner per cycle,
// then face keys and a stable sort, and hands a request to the queue.
// Depends on cfps_pkg.
`default_nettype none
module cfps_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [63:0] row_z,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic signed [6:0] min_x, min_y, min_z, max_x, max_y, max_z,
    input  wire logic [11:0] tex_offset,
    input  wire logic [5:0] size_w, size_h, size_d,
    input  wire logic [11:0] center_x, center_y,
    output logic      req_valid,
    input  wire logic req_stall,
    output cfps_pkg::box_req_t req
);
    typedef enum logic [1:0] {F_IDLE, F_DEPTH, F_SORT, F_OUT} fst_t;
    fst_t st_reg, st_next;
    cfps_pkg::box_req_t box_reg;
    logic [3:0] cnt_reg;
    logic signed [cfps_pkg::QW-1:0] cz_reg [8];
    logic signed [cfps_pkg::KW-1:0] key_reg [6];
    logic [2:0] ord_reg [6];
    logic [2:0] k;
    logic signed [6:0] x, y, z;
    logic signed [cfps_pkg::QW-1:0] dz;
    logic [8:0] u, d9, w9;
    logic [7:0] v, d8, h8;

    assign k = cnt_reg[2:0];
    assign x = k[0] ? box_reg.hi_x : box_reg.lo_x;
    assign y = k[1] ? box_reg.hi_y : box_reg.lo_y;
    assign z = k[2] ? box_reg.hi_z : box_reg.lo_z;
    assign dz = cfps_pkg::QW'($signed(row_z[15:0]) * x)
              + cfps_pkg::QW'($signed(row_z[31:16]) * y)
              + cfps_pkg::QW'($signed(row_z[47:32]) * z)
              + cfps_pkg::QW'($signed(row_z[63:48]));

    assign u = {3'd0, tex_offset[11:6]};
    assign v = {2'd0, tex_offset[5:0]};
    assign d9 = {3'd0, size_d};
    assign w9 = {3'd0, size_w};
    assign d8 = {2'd0, size_d};
    assign h8 = {2'd0, size_h};

    assign in_stall = (st_reg != F_IDLE);
    assign req_valid = (st_reg == F_OUT);
    always_comb
    begin
        req = box_reg;
        for (int i = 0; i < 6; i++)
        begin
            req.order[i*3 +: 3] = ord_reg[i];
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE:  if (in_valid) st_next = F_DEPTH;
            F_DEPTH: if (cnt_reg == 4'd7) st_next = F_SORT;
            F_SORT:  if (cnt_reg == 4'd6) st_next = F_OUT;
            F_OUT:   if (!req_stall) st_next = F_IDLE;
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= F_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg != st_next) cnt_reg <= '0;
            else cnt_reg <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == F_IDLE && in_valid)
        begin
            box_reg.lo_x <= min_x; box_reg.lo_y <= min_y; box_reg.lo_z <= min_z;
            box_reg.hi_x <= max_x; box_reg.hi_y <= max_y; box_reg.hi_z <= max_z;
            box_reg.u0 <= u;
            box_reg.u1 <= u + d9;
            box_reg.u2 <= u + d9 + w9;
            box_reg.u22 <= u + d9 + w9 + w9;
            box_reg.u3 <= u + d9 + w9 + d9;
            box_reg.u4 <= u + d9 + w9 + d9 + w9;
            box_reg.v0 <= v;
            box_reg.v1 <= v + d8;
            box_reg.v2 <= v + d8 + h8;
            box_reg.cen_x <= center_x;
            box_reg.cen_y <= center_y;
            box_reg.order <= '0;
        end
        if (st_reg == F_DEPTH)
            cz_reg[k] <= dz;
        // sort: first the face keys, then one insertion step for each element 1 to 5
        if (st_reg == F_SORT)
        begin
            if (cnt_reg == 4'd0)
            begin
                for (int f = 0; f < 6; f++)
                begin
                    key_reg[f] <= cfps_pkg::KW'(cz_reg[cfps_pkg::face_corner(3'(f), 2'd0)])
                                + cfps_pkg::KW'(cz_reg[cfps_pkg::face_corner(3'(f), 2'd1)])
                                + cfps_pkg::KW'(cz_reg[cfps_pkg::face_corner(3'(f), 2'd2)])
                                + cfps_pkg::KW'(cz_reg[cfps_pkg::face_corner(3'(f), 2'd3)]);
                    ord_reg[f] <= 3'(f);
                end
            end
            else if (cnt_reg <= 4'd5)
            begin
                // insert element i into sorted prefix by compare-shift network
                for (int j = 0; j < 6; j++)
                begin
                    if (j <= int'(cnt_reg))
                    begin
                        // whether prefix entries j and j-1 (below i) have a key > new key
                        logic gt_j, gt_jm1;
                        gt_j = (j < int'(cnt_reg)) &&
                               (key_reg[j] > key_reg[cnt_reg[2:0]]);
                        gt_jm1 = (j > 0) && (key_reg[(j+5)%6] > key_reg[cnt_reg[2:0]]);
                        if (gt_j && j < int'(cnt_reg))
                        begin
                            if (j > 0 && !gt_jm1)
                            begin
                                key_reg[j] <= key_reg[cnt_reg[2:0]];
                                ord_reg[j] <= ord_reg[cnt_reg[2:0]];
                            end
                            else if (j == 0)
                            begin
                                key_reg[0] <= key_reg[cnt_reg[2:0]];
                                ord_reg[0] <= ord_reg[cnt_reg[2:0]];
                            end
                            if (j < 5)
                            begin
                                key_reg[j+1] <= key_reg[j];
                                ord_reg[j+1] <= ord_reg[j];
                            end
                        end
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/cfps_queue.sv
// Two-entry request queue between front and back.
// Depends on cfps_pkg.
`default_nettype none
module cfps_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_stall,
    input  wire cfps_pkg::box_req_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_stall,
    output cfps_pkg::box_req_t rd_data
);
    cfps_pkg::box_req_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

>>> rtl/core/cfps_back.sv
// Back part: walks 24 vertices of a sorted box, one per cycle while out_stall is
// low, through a two-stage pipe (multiply, then round/saturate into the output register).
// Depends on cfps_pkg.
`default_nettype none
module cfps_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [63:0] row_x,
    input  wire logic [63:0] row_y,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire cfps_pkg::box_req_t req,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic signed [17:0] screen_x,
    output logic signed [17:0] screen_y,
    output logic [8:0] tex_u,
    output logic [7:0] tex_v,
    output logic [2:0] face_index,
    output logic [1:0] corner,
    output logic       last
);
    typedef struct packed {
        logic signed [cfps_pkg::QW-1:0] qx, qy;
        logic [11:0] cx, cy;
        logic [8:0] u;
        logic [7:0] v;
        logic [2:0] f;
        logic [1:0] j;
        logic l;
    } mid_t;

    logic [4:0] vtx_reg;
    logic s1_v_reg, s2_v_reg;
    mid_t s1_reg;
    logic adv2, adv1, take;
    logic [2:0] slot, f, c;
    logic [1:0] j;
    logic signed [6:0] x, y, z;
    logic [8:0] umin, umax;
    logic [7:0] vmin, vmax;
    logic signed [cfps_pkg::QW+1:0] sx, sy, rx, ry;
    logic signed [cfps_pkg::QW-1:0] ny;

    assign adv2 = !s2_v_reg || !out_stall;
    assign adv1 = !s1_v_reg || adv2;
    assign take = req_valid && adv1;
    assign req_stall = !(take && vtx_reg == 5'd23);
    assign out_valid = s2_v_reg;

    assign slot = vtx_reg[4:2];
    assign j = vtx_reg[1:0];
    assign f = req.order[slot*3 +: 3];
    assign c = cfps_pkg::face_corner(f, j);
    assign x = c[0] ? req.hi_x : req.lo_x;
    assign y = c[1] ? req.hi_y : req.lo_y;
    assign z = c[2] ? req.hi_z : req.lo_z;

    always_comb
    begin
        case (f)
            3'd0: begin umin = req.u1; vmin = req.v0; umax = req.u2;  vmax = req.v1; end
            3'd1: begin umin = req.u2; vmin = req.v1; umax = req.u22; vmax = req.v0; end
            3'd2: begin umin = req.u0; vmin = req.v1; umax = req.u1;  vmax = req.v2; end
            3'd3: begin umin = req.u1; vmin = req.v1; umax = req.u2;  vmax = req.v2; end
            3'd4: begin umin = req.u2; vmin = req.v1; umax = req.u3;  vmax = req.v2; end
            3'd5: begin umin = req.u3; vmin = req.v1; umax = req.u4;  vmax = req.v2; end
            default: begin umin = '0; vmin = '0; umax = '0; vmax = '0; end
        endcase
    end

    // floor((q+32)/64) + 16*center, saturated; q is negated for y
    assign ny = -s1_reg.qy;
    assign rx = ((cfps_pkg::QW+2)'(s1_reg.qx) + (cfps_pkg::QW+2)'(32)) >>> 6;
    assign ry = ((cfps_pkg::QW+2)'(ny) + (cfps_pkg::QW+2)'(32)) >>> 6;
    assign sx = rx + $signed({12'd0, s1_reg.cx, 4'd0});
    assign sy = ry + $signed({12'd0, s1_reg.cy, 4'd0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (take) vtx_reg <= (vtx_reg == 5'd23) ? 5'd0 : vtx_reg + 5'd1;
            if (adv1) s1_v_reg <= req_valid;
            if (adv2) s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg.qx <= cfps_pkg::QW'($signed(row_x[15:0]) * x)
                       + cfps_pkg::QW'($signed(row_x[31:16]) * y)
                       + cfps_pkg::QW'($signed(row_x[47:32]) * z)
                       + cfps_pkg::QW'($signed(row_x[63:48]));
            s1_reg.qy <= cfps_pkg::QW'($signed(row_y[15:0]) * x)
                       + cfps_pkg::QW'($signed(row_y[31:16]) * y)
                       + cfps_pkg::QW'($signed(row_y[47:32]) * z)
                       + cfps_pkg::QW'($signed(row_y[63:48]));
            s1_reg.cx <= req.cen_x;
            s1_reg.cy <= req.cen_y;
            s1_reg.u <= (j == 2'd1 || j == 2'd2) ? umax : umin;
            s1_reg.v <= j[1] ? vmax : vmin;
            s1_reg.f <= f;
            s1_reg.j <= j;
            s1_reg.l <= (vtx_reg == 5'd23);
        end
        if (adv2 && s1_v_reg)
        begin
            screen_x <= (sx > (cfps_pkg::QW+2)'(cfps_pkg::ScrMax)) ? cfps_pkg::ScrMax :
                        (sx < (cfps_pkg::QW+2)'(cfps_pkg::ScrMin)) ? cfps_pkg::ScrMin :
                        sx[17:0];
            screen_y <= (sy > (cfps_pkg::QW+2)'(cfps_pkg::ScrMax)) ? cfps_pkg::ScrMax :
                        (sy < (cfps_pkg::QW+2)'(cfps_pkg::ScrMin)) ? cfps_pkg::ScrMin :
                        sy[17:0];
            tex_u <= s1_reg.u;
            tex_v <= s1_reg.v;
            face_index <= s1_reg.f;
            corner <= s1_reg.j;
            last <= s1_reg.l;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/cube_face_project_sort.sv
// Top level of the cube face project/sort block: config rows, front, queue, back.
// Depends on cfps_pkg, cfps_front, cfps_queue, cfps_back.
`default_nettype none
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | min_*/max_*, tex_offset, size_*, center_*
// out     | out_valid | out_stall | screen_x/y, tex_u/v, face_index, corner, last
// cfg     | cfg_we    | -         | cfg_index, cfg_data
// Each box yields 24 vertices, one per cycle while out_stall is low; the back
// end's vertex walk sets the sustained box rate. The front works through each box
// in steps (accept, 8 corner depths, key sums, 5 insertion steps, one spare, handoff)
// and holds in_stall high meanwhile; a two-request queue lets it run ahead of
// the back. Reset clears the rows and all control.
module cube_face_project_sort (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic signed [6:0] min_x, min_y, min_z, max_x, max_y, max_z,
    input  wire logic [11:0] tex_offset,
    input  wire logic [5:0] size_w, size_h, size_d,
    input  wire logic [11:0] center_x, center_y,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic signed [17:0] screen_x,
    output logic signed [17:0] screen_y,
    output logic [8:0] tex_u,
    output logic [7:0] tex_v,
    output logic [2:0] face_index,
    output logic [1:0] corner,
    output logic       last
);
    logic [63:0] row_x_reg, row_y_reg, row_z_reg;
    logic fq_valid, fq_stall, qb_valid, qb_stall;
    cfps_pkg::box_req_t fq_req, qb_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            row_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfps_pkg::RegRowX: row_x_reg <= cfg_data;
                cfps_pkg::RegRowY: row_y_reg <= cfg_data;
                cfps_pkg::RegRowZ: row_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cfps_front u_front (
        .clk(clk), .rst_n(rst_n), .row_z(row_z_reg),
        .in_valid(in_valid), .in_stall(in_stall),
        .min_x(min_x), .min_y(min_y), .min_z(min_z),
        .max_x(max_x), .max_y(max_y), .max_z(max_z),
        .tex_offset(tex_offset), .size_w(size_w), .size_h(size_h), .size_d(size_d),
        .center_x(center_x), .center_y(center_y),
        .req_valid(fq_valid), .req_stall(fq_stall), .req(fq_req)
    );

    cfps_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_req),
        .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_req)
    );

    cfps_back u_back (
        .clk(clk), .rst_n(rst_n), .row_x(row_x_reg), .row_y(row_y_reg),
        .req_valid(qb_valid), .req_stall(qb_stall), .req(qb_req),
        .out_valid(out_valid), .out_stall(out_stall),
        .screen_x(screen_x), .screen_y(screen_y), .tex_u(tex_u), .tex_v(tex_v),
        .face_index(face_index), .corner(corner), .last(last)
    );
endmodule
`default_nettype wire
